### design/assert_macros.svh
// Assertion macros shared by the frame header parser modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_ALWAYS(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define ASSERT_NEVER(label, clk, rst, expr, msg) \
   label: assert property (@(posedge clk) disable iff (rst) !(expr)) else $error(msg);
`else
`define ASSERT_ALWAYS(label, clk, rst, prop, msg)
`define ASSERT_NEVER(label, clk, rst, expr, msg)
`endif
`endif

### design/mfhp_pkg.sv
// Package with types, codes and helper functions of the frame header parser.
`timescale 1ns / 1ps
package mfhp_pkg;

   localparam logic [4:0] BASE_HDR_LEN = 5'd3;
   localparam logic [7:0] FCS_LEN      = 8'd2;
   localparam logic [7:0] MIN_PHY_LEN  = 8'd5;
   localparam logic [4:0] LONG_ADDR_LEN = 5'd8;
   localparam logic [4:0] LONG_DEST_LEN = 5'd10;
   localparam logic [4:0] SHORT_DEST_LEN = 5'd4;
   localparam logic [1:0] MODE_NONE  = 2'd0;
   localparam logic [1:0] MODE_SHORT = 2'd2;
   localparam logic [1:0] MODE_LONG  = 2'd3;

   typedef enum logic [2:0] {
      PH_LEN,
      PH_FCF_LO,
      PH_FCF_HI,
      PH_HDR,
      PH_PAYLOAD,
      PH_FCS,
      PH_SKIP
   } phase_type;

   typedef enum logic [1:0] {
      KIND_HEADER,
      KIND_PAYLOAD,
      KIND_ERROR
   } kind_type;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       frame_start;
   } item_type;

   typedef struct packed {
      kind_type    kind;
      logic [15:0] control_word;
      logic [7:0]  sequence_number;
      logic [15:0] dst_pan_id;
      logic [15:0] dest_short_addr;
      logic [15:0] src_pan;
      logic [15:0] src_short_addr;
      logic [7:0]  body_len;
      logic [7:0]  payload_byte;
      logic        last_payload;
   } result_type;

   function automatic logic [1:0] dest_mode(input logic [15:0] ctrl);
      return ctrl[11:10];
   endfunction

   function automatic logic [1:0] src_mode(input logic [15:0] ctrl);
      return ctrl[15:14];
   endfunction

   function automatic logic compressed(input logic [15:0] ctrl);
      return (dest_mode(ctrl) != MODE_NONE) && (src_mode(ctrl) != MODE_NONE) && ctrl[6];
   endfunction

   function automatic logic [4:0] dest_len(input logic [15:0] ctrl);
      logic [4:0] len;
      unique case (dest_mode(ctrl))
         MODE_SHORT: len = SHORT_DEST_LEN;
         MODE_LONG:  len = LONG_DEST_LEN;
         default:    len = 5'd0;
      endcase
      return len;
   endfunction

   function automatic logic [4:0] src_pan_len(input logic [15:0] ctrl);
      return (src_mode(ctrl) >= MODE_SHORT && !compressed(ctrl)) ? 5'd2 : 5'd0;
   endfunction

   function automatic logic [4:0] src_len(input logic [15:0] ctrl);
      logic [4:0] len;
      unique case (src_mode(ctrl))
         MODE_SHORT: len = 5'd2;
         MODE_LONG:  len = LONG_ADDR_LEN;
         default:    len = 5'd0;
      endcase
      return src_pan_len(ctrl) + len;
   endfunction

   function automatic logic [15:0] put_byte(input logic [15:0] word, input logic hi,
                                            input logic [7:0] b);
      return hi ? {b, word[7:0]} : {word[15:8], b};
   endfunction

endpackage

### design/mfhp_input_stage.sv
// Input register that holds one received byte until the parser takes it.
`timescale 1ns / 1ps
module mfhp_input_stage (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_tvalid,
   output logic              req_tready,
   input  mfhp_pkg::item_type req_item,
   input  logic              take,
   output logic              item_valid,
   output mfhp_pkg::item_type item
);
   import mfhp_pkg::*;

   logic     valid_ff;
   logic     valid_in;
   item_type item_ff;

   assign req_tready = !valid_ff || take;
   assign valid_in   = req_tready ? req_tvalid : valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      if (req_tready && req_tvalid) begin
         item_ff <= req_item;
      end
   end

   assign item_valid = valid_ff;
   assign item       = item_ff;

endmodule

### design/mfhp_parse_core.sv
// Parser state and the per-byte update that forms header, payload and error results.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module mfhp_parse_core (
   input  logic                clock,
   input  logic                reset,
   input  logic                step,
   input  mfhp_pkg::item_type  item,
   output logic                res_valid,
   output mfhp_pkg::result_type res
);
   import mfhp_pkg::*;

   phase_type   phase_ff, phase_in;
   logic [7:0]  bp_ff, bp_in;
   logic [7:0]  flen_ff, flen_in;
   logic [15:0] ctrl_ff, ctrl_in;
   logic [7:0]  seq_ff, seq_in;
   logic [15:0] dpan_ff, dpan_in;
   logic [15:0] daddr_ff, daddr_in;
   logic [15:0] span_ff, span_in;
   logic [15:0] saddr_ff, saddr_in;
   logic [4:0]  hdr_ff, hdr_in;
   logic [7:0]  left_ff, left_in;

   logic        restart;
   logic [7:0]  b;
   logic [15:0] ctrl_hi;
   logic [4:0]  hdr_len_new;
   logic        short_hdr;
   logic [7:0]  skip_n;
   logic [7:0]  bp_next;
   logic        hdr_done;
   logic [7:0]  plen;
   logic [7:0]  left_dec;
   logic [7:0]  k_full;
   logic [4:0]  k;
   logic [4:0]  dl;
   logic [4:0]  spl;
   logic [4:0]  so;
   logic [4:0]  so_rel;

   assign b           = item.data_byte;
   assign restart     = item.frame_start || (phase_ff == PH_LEN) || (phase_ff > PH_SKIP);
   assign ctrl_hi     = {b, ctrl_ff[7:0]};
   assign hdr_len_new = BASE_HDR_LEN + dest_len(ctrl_hi) + src_len(ctrl_hi);
   assign short_hdr   = flen_ff < ({3'b000, hdr_len_new} + FCS_LEN);
   assign skip_n      = flen_ff - FCS_LEN;
   assign bp_next     = bp_ff + 8'd1;
   assign hdr_done    = bp_next >= {3'b000, hdr_ff};
   assign plen        = flen_ff - {3'b000, hdr_ff} - FCS_LEN;
   assign left_dec    = (left_ff != 8'd0) ? left_ff - 8'd1 : 8'd0;
   assign k_full      = bp_next - 8'd4;
   assign k           = k_full[4:0];
   assign dl          = dest_len(ctrl_ff);
   assign spl         = src_pan_len(ctrl_ff);
   assign so          = k - dl;
   assign so_rel      = so - spl;

   // Next parse phase.
   always_comb begin
      phase_in = phase_ff;
      if (step) begin
         if (restart) begin
            if (b < MIN_PHY_LEN) begin
               phase_in = (b != 8'd0) ? PH_SKIP : PH_LEN;
            end else begin
               phase_in = PH_FCF_LO;
            end
         end else begin
            unique case (phase_ff)
               PH_FCF_LO: begin
                  phase_in = PH_FCF_HI;
               end
               PH_FCF_HI: begin
                  if (short_hdr) begin
                     phase_in = (skip_n != 8'd0) ? PH_SKIP : PH_LEN;
                  end else begin
                     phase_in = PH_HDR;
                  end
               end
               PH_HDR: begin
                  if (hdr_done) begin
                     phase_in = (plen != 8'd0) ? PH_PAYLOAD : PH_FCS;
                  end
               end
               PH_PAYLOAD: begin
                  if (left_dec == 8'd0) begin
                     phase_in = PH_FCS;
                  end
               end
               default: begin
                  if (left_ff <= 8'd1) begin
                     phase_in = PH_LEN;
                  end
               end
            endcase
         end
      end
   end

   // Field registers and the result of the current byte.
   always_comb begin
      bp_in     = bp_ff;
      flen_in   = flen_ff;
      ctrl_in   = ctrl_ff;
      seq_in    = seq_ff;
      dpan_in   = dpan_ff;
      daddr_in  = daddr_ff;
      span_in   = span_ff;
      saddr_in  = saddr_ff;
      hdr_in    = hdr_ff;
      left_in   = left_ff;
      res_valid = 1'b0;
      res       = '0;
      if (step) begin
         if (restart) begin
            bp_in    = 8'd0;
            flen_in  = b;
            ctrl_in  = 16'd0;
            seq_in   = 8'd0;
            dpan_in  = 16'd0;
            daddr_in = 16'd0;
            span_in  = 16'd0;
            saddr_in = 16'd0;
            hdr_in   = BASE_HDR_LEN;
            left_in  = 8'd0;
            if (b < MIN_PHY_LEN) begin
               res_valid = 1'b1;
               res.kind  = KIND_ERROR;
               left_in   = b;
            end
         end else begin
            bp_in = bp_next;
            unique case (phase_ff)
               PH_FCF_LO: begin
                  ctrl_in = {8'h00, b};
               end
               PH_FCF_HI: begin
                  ctrl_in = ctrl_hi;
                  hdr_in  = hdr_len_new;
                  if (short_hdr) begin
                     res_valid        = 1'b1;
                     res.kind         = KIND_ERROR;
                     res.control_word = ctrl_hi;
                     left_in          = skip_n;
                  end
               end
               PH_HDR: begin
                  if (bp_next == 8'd3) begin
                     seq_in = b;
                  end else if (bp_next > 8'd3) begin
                     if (k < dl) begin
                        if (dest_mode(ctrl_ff) == MODE_SHORT) begin
                           if (k < 5'd2) begin
                              dpan_in = put_byte(dpan_ff, k[0], b);
                           end else begin
                              daddr_in = put_byte(daddr_ff, k[0], b);
                           end
                        end
                     end else if (so < spl) begin
                        span_in = put_byte(span_ff, so[0], b);
                     end else if (src_mode(ctrl_ff) == MODE_SHORT && so_rel < 5'd2) begin
                        saddr_in = put_byte(saddr_ff, so_rel[0], b);
                     end
                  end
                  if (hdr_done) begin
                     res_valid           = 1'b1;
                     res.kind            = KIND_HEADER;
                     res.control_word    = ctrl_ff;
                     res.sequence_number = seq_in;
                     res.dst_pan_id      = dpan_in;
                     res.dest_short_addr = daddr_in;
                     res.src_pan         = span_in;
                     res.src_short_addr  = saddr_in;
                     res.body_len        = plen;
                     left_in             = (plen != 8'd0) ? plen : FCS_LEN;
                  end
               end
               PH_PAYLOAD: begin
                  left_in          = left_dec;
                  res_valid        = 1'b1;
                  res.kind         = KIND_PAYLOAD;
                  res.payload_byte = b;
                  if (left_dec == 8'd0) begin
                     res.last_payload = 1'b1;
                     left_in          = FCS_LEN;
                  end
               end
               default: begin
                  left_in = (left_ff <= 8'd1) ? 8'd0 : left_ff - 8'd1;
               end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_LEN;
         hdr_ff   <= BASE_HDR_LEN;
         left_ff  <= 8'd0;
      end else begin
         phase_ff <= phase_in;
         hdr_ff   <= hdr_in;
         left_ff  <= left_in;
      end
      bp_ff    <= bp_in;
      flen_ff  <= flen_in;
      ctrl_ff  <= ctrl_in;
      seq_ff   <= seq_in;
      dpan_ff  <= dpan_in;
      daddr_ff <= daddr_in;
      span_ff  <= span_in;
      saddr_ff <= saddr_in;
   end

   `ASSERT_NEVER(a_hdr_len_range, clock, reset, (hdr_ff < 5'd3) || (hdr_ff > 5'd23), "header length out of range")
   `ASSERT_ALWAYS(a_count_live, clock, reset, ((phase_ff == PH_PAYLOAD) || (phase_ff == PH_FCS) || (phase_ff == PH_SKIP)) |-> (left_ff != 8'd0), "byte counter empty in a counted phase")
   `ASSERT_ALWAYS(a_last_to_fcs, clock, reset, (step && res_valid && res.last_payload) |=> ((phase_ff == PH_FCS) && (left_ff == 8'd2)), "last payload byte not followed by checksum")

endmodule

### design/mfhp_output_stage.sv
// Result register that holds one result until the downstream side takes it.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module mfhp_output_stage (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 step,
   input  logic                 res_valid,
   input  mfhp_pkg::result_type res,
   output logic                 out_free,
   output logic                 rsp_tvalid,
   input  logic                 rsp_tready,
   output mfhp_pkg::result_type rsp_res
);
   import mfhp_pkg::*;

   logic       valid_ff;
   logic       valid_in;
   result_type res_ff;

   assign out_free = !valid_ff || rsp_tready;
   assign valid_in = out_free ? (step && res_valid) : valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      if (out_free && step && res_valid) begin
         res_ff <= res;
      end
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_res    = res_ff;

   `ASSERT_NEVER(a_last_kind, clock, reset, valid_ff && res_ff.last_payload && (res_ff.kind != KIND_PAYLOAD), "last flag on a non-payload result")
   `ASSERT_NEVER(a_error_clean, clock, reset, valid_ff && (res_ff.kind == KIND_ERROR) && (res_ff.body_len != 8'd0), "error result carries a payload length")

endmodule

### design/mac_frame_header_parser.sv
// Top level of the 802.15.4 MAC frame header parser.
// An accepted request waits in the input register until the result register is free;
// the parser update then writes its result into the result register.
// Throughput: one request per cycle while rsp_tready is high; the per-byte state update
// is a single pass of logic. Reset: synchronous, active high; empties both registers and
// returns the parser to waiting for a PHY length byte.
`timescale 1ns / 1ps
module mac_frame_header_parser (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [7:0]   req_tdata,  // [7:0] data_byte
   input  logic         req_tuser,  // [0] frame_start
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // [15:0] control_word, [23:16] sequence_number, [39:24] destination PAN,
   // [55:40] dest_short_addr, [71:56] src_pan, [87:72] src_short_addr,
   // [95:88] payload length, [103:96] payload_byte
   output logic [103:0] rsp_tdata,
   output logic [1:0]   rsp_tuser,  // [1:0] result_kind
   output logic         rsp_tlast   // last_payload
);
   import mfhp_pkg::*;

   item_type   req_item;
   item_type   item;
   logic       item_valid;
   logic       out_free;
   logic       step;
   logic       res_valid;
   result_type res;
   result_type rsp_res;

   assign req_item.data_byte   = req_tdata;
   assign req_item.frame_start = req_tuser;
   assign step                 = item_valid && out_free;

   mfhp_input_stage u_input (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_item   (req_item),
      .take       (out_free),
      .item_valid (item_valid),
      .item       (item)
   );

   mfhp_parse_core u_core (
      .clock     (clock),
      .reset     (reset),
      .step      (step),
      .item      (item),
      .res_valid (res_valid),
      .res       (res)
   );

   mfhp_output_stage u_output (
      .clock      (clock),
      .reset      (reset),
      .step       (step),
      .res_valid  (res_valid),
      .res        (res),
      .out_free   (out_free),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_res    (rsp_res)
   );

   assign rsp_tdata = {rsp_res.payload_byte, rsp_res.body_len, rsp_res.src_short_addr,
                       rsp_res.src_pan, rsp_res.dest_short_addr, rsp_res.dst_pan_id,
                       rsp_res.sequence_number, rsp_res.control_word};
   assign rsp_tuser = rsp_res.kind;
   assign rsp_tlast = rsp_res.last_payload;

endmodule

### dv/mfhp_frame_checker.sv
// Checker for the frame header parser: predicts each response from the requests and compares.
`timescale 1ns / 1ps
module mfhp_frame_checker (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   input  logic         req_tready,
   input  logic [7:0]   req_tdata,
   input  logic         req_tuser,
   input  logic         rsp_tvalid,
   input  logic         rsp_tready,
   input  logic [103:0] rsp_tdata,
   input  logic [1:0]   rsp_tuser,
   input  logic         rsp_tlast,
   output int           fail_count,
   output int           pending,
   output int           parsed_count,
   output int           headers_seen,
   output int           payload_seen,
   output int           errors_seen
);
   import mfhp_pkg::*;

   phase_type   phase;
   logic [7:0]  pos;
   logic [7:0]  frame_len;
   logic [7:0]  seq;
   logic [7:0]  remaining;
   logic [4:0]  hdr_len;
   logic [15:0] ctrl;
   logic [15:0] dpan;
   logic [15:0] daddr;
   logic [15:0] span;
   logic [15:0] saddr;
   result_type  expected_results[$];
   int          mismatches;
   int          parsed;
   int          headers;
   int          payloads;
   int          length_errors;

   function automatic logic [4:0] dest_field_bytes(input logic [15:0] c);
      if (c[11:10] == MODE_SHORT) begin
         return SHORT_DEST_LEN;
      end else if (c[11:10] == MODE_LONG) begin
         return LONG_DEST_LEN;
      end
      return 5'd0;
   endfunction

   function automatic logic [4:0] src_pan_bytes(input logic [15:0] c);
      logic squeezed;
      squeezed = (c[11:10] != MODE_NONE) && (c[15:14] != MODE_NONE) && c[6];
      return (c[15:14] >= MODE_SHORT && !squeezed) ? 5'd2 : 5'd0;
   endfunction

   function automatic logic [4:0] src_field_bytes(input logic [15:0] c);
      logic [4:0] n;
      n = src_pan_bytes(c);
      if (c[15:14] == MODE_SHORT) begin
         n = n + 5'd2;
      end else if (c[15:14] == MODE_LONG) begin
         n = n + LONG_ADDR_LEN;
      end
      return n;
   endfunction

   task automatic clear_frame();
      pos       = '0;
      frame_len = '0;
      ctrl      = '0;
      seq       = '0;
      dpan      = '0;
      daddr     = '0;
      span      = '0;
      saddr     = '0;
      hdr_len   = BASE_HDR_LEN;
      remaining = '0;
   endtask

   task automatic skip_bytes(input logic [7:0] n);
      remaining = n;
      phase = (n != 0) ? PH_SKIP : PH_LEN;
   endtask

   // Address bytes follow the sequence number; k counts from the first of them.
   task automatic place_address_byte(input logic [7:0] k, input logic [7:0] b);
      logic [7:0] dl;
      logic [7:0] pl;
      logic [7:0] so;
      dl = 8'(dest_field_bytes(ctrl));
      pl = 8'(src_pan_bytes(ctrl));
      if (k < dl) begin
         if (ctrl[11:10] == MODE_SHORT) begin
            if (k < 2) begin
               dpan[k[0]*8 +: 8] = b;
            end else begin
               daddr[k[0]*8 +: 8] = b;
            end
         end
      end else begin
         so = k - dl;
         if (so < pl) begin
            span[so[0]*8 +: 8] = b;
         end else if (ctrl[15:14] == MODE_SHORT && (so - pl) < 2) begin
            saddr[so[0]*8 +: 8] = b;
         end
      end
   endtask

   task automatic parse_byte(input logic [7:0] b, input logic fs);
      result_type r;
      logic [7:0] plen;
      r = '0;
      if (fs || !(phase inside {PH_FCS, PH_SKIP})) begin
         parsed++;
      end
      if (fs || phase == PH_LEN || phase > PH_SKIP) begin
         clear_frame();
         frame_len = b;
         if (b < MIN_PHY_LEN) begin
            r.kind = KIND_ERROR;
            expected_results.push_back(r);
            skip_bytes(b);
         end else begin
            phase = PH_FCF_LO;
         end
      end else begin
         pos = pos + 8'd1;
         case (phase)
            PH_FCF_LO: begin
               ctrl = {8'h00, b};
               phase = PH_FCF_HI;
            end
            PH_FCF_HI: begin
               ctrl[15:8] = b;
               hdr_len = BASE_HDR_LEN + dest_field_bytes(ctrl) + src_field_bytes(ctrl);
               if (frame_len < 8'(hdr_len) + FCS_LEN) begin
                  r.kind = KIND_ERROR;
                  r.control_word = ctrl;
                  expected_results.push_back(r);
                  skip_bytes(frame_len - FCS_LEN);
               end else begin
                  phase = PH_HDR;
               end
            end
            PH_HDR: begin
               if (pos == 8'd3) begin
                  seq = b;
               end else if (pos > 8'd3) begin
                  place_address_byte(pos - 8'd4, b);
               end
               if (pos >= 8'(hdr_len)) begin
                  plen = frame_len - 8'(hdr_len) - FCS_LEN;
                  r.kind            = KIND_HEADER;
                  r.control_word    = ctrl;
                  r.sequence_number = seq;
                  r.dst_pan_id      = dpan;
                  r.dest_short_addr = daddr;
                  r.src_pan         = span;
                  r.src_short_addr  = saddr;
                  r.body_len        = plen;
                  expected_results.push_back(r);
                  if (plen != 0) begin
                     remaining = plen;
                     phase = PH_PAYLOAD;
                  end else begin
                     remaining = FCS_LEN;
                     phase = PH_FCS;
                  end
               end
            end
            PH_PAYLOAD: begin
               if (remaining != 0) begin
                  remaining = remaining - 8'd1;
               end
               r.kind = KIND_PAYLOAD;
               r.payload_byte = b;
               if (remaining == 0) begin
                  r.last_payload = 1'b1;
                  remaining = FCS_LEN;
                  phase = PH_FCS;
               end
               expected_results.push_back(r);
            end
            default: begin
               if (remaining <= 8'd1) begin
                  remaining = '0;
                  phase = PH_LEN;
               end else begin
                  remaining = remaining - 8'd1;
               end
            end
         endcase
      end
   endtask

   function automatic void check_field(input string name, input logic [15:0] want,
                                       input logic [15:0] got);
      if (got !== want) begin
         mismatches++;
         $display("%0t: %s mismatch, expected %h, got %h", $time, name, want, got);
      end
   endfunction

   always @(posedge clock) begin : monitor
      result_type want;
      if (reset) begin
         clear_frame();
         phase = PH_LEN;
         expected_results.delete();
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (expected_results.size() == 0) begin
               mismatches++;
               $display("%0t: unexpected response, expected none, got kind %h data %h",
                        $time, rsp_tuser, rsp_tdata);
            end else begin
               want = expected_results.pop_front();
               case (want.kind)
                  KIND_HEADER:  headers++;
                  KIND_PAYLOAD: payloads++;
                  default:      length_errors++;
               endcase
               check_field("result_kind", 16'(want.kind), 16'(rsp_tuser));
               check_field("control_word", want.control_word, rsp_tdata[15:0]);
               check_field("sequence_number", 16'(want.sequence_number), 16'(rsp_tdata[23:16]));
               check_field("dst_pan_id", want.dst_pan_id, rsp_tdata[39:24]);
               check_field("dest_short_addr", want.dest_short_addr, rsp_tdata[55:40]);
               check_field("src_pan", want.src_pan, rsp_tdata[71:56]);
               check_field("src_short_addr", want.src_short_addr, rsp_tdata[87:72]);
               check_field("body_len", 16'(want.body_len), 16'(rsp_tdata[95:88]));
               check_field("payload_byte", 16'(want.payload_byte), 16'(rsp_tdata[103:96]));
               check_field("last_payload", 16'(want.last_payload), 16'(rsp_tlast));
            end
         end
         if (req_tvalid && req_tready) begin
            parse_byte(req_tdata, req_tuser);
         end
      end
      fail_count   <= mismatches;
      pending      <= expected_results.size();
      parsed_count <= parsed;
      headers_seen <= headers;
      payload_seen <= payloads;
      errors_seen  <= length_errors;
   end

endmodule

### dv/tb_mac_frame_header_parser.sv
// Testbench top for the frame header parser: clock, reset, frame stimulus and the verdict.
`timescale 1ns / 1ps
module tb_mac_frame_header_parser;
   import mfhp_pkg::*;

   localparam int ITEM_TARGET = 1400;
   localparam int CYCLE_LIMIT = 600000;

   logic         clock;
   logic         reset;
   logic         req_tvalid;
   logic         req_tready;
   logic [7:0]   req_tdata;
   logic         req_tuser;
   logic         rsp_tvalid;
   logic         rsp_tready;
   logic [103:0] rsp_tdata;
   logic [1:0]   rsp_tuser;
   logic         rsp_tlast;

   int fail_count;
   int pending;
   int parsed_count;
   int headers_seen;
   int payload_seen;
   int errors_seen;
   int cycles;
   int requests_sent;
   int rsp_run;
   bit steady_req;
   bit steady_rsp;
   bit force_start;
   logic [8:0] frame_q[$];  // {frame_start, data_byte} per request

   mac_frame_header_parser uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   mfhp_frame_checker frame_checker (
      .clock        (clock),
      .reset        (reset),
      .req_tvalid   (req_tvalid),
      .req_tready   (req_tready),
      .req_tdata    (req_tdata),
      .req_tuser    (req_tuser),
      .rsp_tvalid   (rsp_tvalid),
      .rsp_tready   (rsp_tready),
      .rsp_tdata    (rsp_tdata),
      .rsp_tuser    (rsp_tuser),
      .rsp_tlast    (rsp_tlast),
      .fail_count   (fail_count),
      .pending      (pending),
      .parsed_count (parsed_count),
      .headers_seen (headers_seen),
      .payload_seen (payload_seen),
      .errors_seen  (errors_seen)
   );

   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("Timeout after %0d cycles with %0d responses outstanding", cycles, pending);
         $display("Simulation FAILED");
         $finish;
      end
   end

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 60) begin
         return 0;
      end else if (r < 88) begin
         return $urandom_range(1, 3);
      end else if (r < 98) begin
         return $urandom_range(4, 12);
      end
      return $urandom_range(20, 60);
   endfunction

   // Response side alternates ready runs and stalls; some runs are long and stall-free.
   always @(posedge clock) begin
      if (rsp_run > 0) begin
         rsp_run--;
      end else if (rsp_tready) begin
         rsp_tready <= 1'b0;
         rsp_run = pick_gap();
      end else begin
         rsp_tready <= 1'b1;
         steady_rsp = ($urandom_range(0, 9) == 0);
         rsp_run = steady_rsp ? $urandom_range(100, 300) : $urandom_range(0, 30);
      end
   end

   function automatic int mhr_bytes(input logic [15:0] c);
      int n;
      n = 3;
      case (c[11:10])
         MODE_SHORT: n += 4;
         MODE_LONG:  n += 10;
         default:    ;
      endcase
      case (c[15:14])
         MODE_SHORT: n += 2;
         MODE_LONG:  n += 8;
         default:    ;
      endcase
      if (c[15:14] >= MODE_SHORT && !(c[11:10] != MODE_NONE && c[6])) begin
         n += 2;
      end
      return n;
   endfunction

   task automatic send_req(input logic [7:0] b, input logic fs);
      int gap;
      gap = steady_req ? 0 : pick_gap();
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= b;
      req_tuser  <= fs;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      requests_sent++;
   endtask

   task automatic send_frame();
      foreach (frame_q[i]) begin
         send_req(frame_q[i][7:0], frame_q[i][8]);
      end
      frame_q.delete();
   endtask

   task automatic wait_idle();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
   endtask

   function automatic logic start_flag();
      return force_start ? 1'b1 : 1'($urandom_range(0, 1));
   endfunction

   task automatic push_filler(input int n);
      repeat (n) frame_q.push_back({1'b0, 8'($urandom)});
   endtask

   task automatic build_good_frame(input bit truncate);
      logic [15:0] c;
      int hl;
      int pl;
      int r;
      int keep;
      c  = 16'($urandom);
      hl = mhr_bytes(c);
      r  = $urandom_range(0, 99);
      if (r < 80) begin
         pl = $urandom_range(0, 12);
      end else if (r < 96) begin
         pl = $urandom_range(13, 60);
      end else begin
         pl = $urandom_range(61, 253 - hl);
      end
      frame_q.push_back({start_flag(), 8'(hl + pl + 2)});
      frame_q.push_back({1'b0, c[7:0]});
      frame_q.push_back({1'b0, c[15:8]});
      push_filler(hl + pl);
      force_start = 1'b0;
      if (truncate) begin
         keep = $urandom_range(1, frame_q.size() - 1);
         while (frame_q.size() > keep) void'(frame_q.pop_back());
         force_start = 1'b1;
      end
   endtask

   task automatic build_short_length();
      int len;
      len = $urandom_range(0, 4);
      frame_q.push_back({start_flag(), 8'(len)});
      push_filler(len);
      force_start = 1'b0;
   endtask

   task automatic build_short_control();
      logic [15:0] c;
      int len;
      do c = 16'($urandom); while (mhr_bytes(c) < 4);
      len = $urandom_range(5, mhr_bytes(c) + 1);
      frame_q.push_back({start_flag(), 8'(len)});
      frame_q.push_back({1'b0, c[7:0]});
      frame_q.push_back({1'b0, c[15:8]});
      push_filler(len - 2);
      force_start = 1'b0;
   endtask

   task automatic build_noise();
      repeat ($urandom_range(1, 6)) frame_q.push_back(9'($urandom));
      force_start = 1'b1;
   endtask

   initial begin
      int frame_idx;
      int r;
      cycles        = 0;
      requests_sent = 0;
      rsp_run       = 0;
      steady_req    = 1'b0;
      steady_rsp    = 1'b0;
      force_start   = 1'b0;
      reset      <= 1'b1;
      req_tvalid <= 1'b0;
      req_tdata  <= '0;
      req_tuser  <= 1'b0;
      rsp_tready <= 1'b0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // Zero and tiny lengths, an empty payload, a header longer than the length, an
      // aborted frame, and a reserved destination mode that still compresses the PAN.
      frame_q = '{
         {1'b0, 8'd0},
         {1'b1, 8'd1}, {1'b0, 8'hFF},
         {1'b0, 8'd5}, {1'b0, 8'h00}, {1'b0, 8'h00}, {1'b0, 8'hFF}, {1'b0, 8'h12},
         {1'b0, 8'h34},
         {1'b1, 8'd5}, {1'b0, 8'h00}, {1'b0, 8'h08}, {1'b0, 8'hAA}, {1'b0, 8'h55},
         {1'b0, 8'h00},
         {1'b0, 8'd20}, {1'b0, 8'h41},
         {1'b1, 8'd8}, {1'b0, 8'h40}, {1'b0, 8'h84}, {1'b0, 8'h7E}, {1'b0, 8'hCD},
         {1'b0, 8'hAB}, {1'b0, 8'hFF}, {1'b0, 8'h00}, {1'b0, 8'h00}
      };
      send_frame();
      wait_idle();

      frame_idx = 0;
      while (requests_sent < ITEM_TARGET) begin
         steady_req = ($urandom_range(0, 9) == 0);
         r = $urandom_range(0, 99);
         if (r < 72) begin
            build_good_frame(1'b0);
         end else if (r < 80) begin
            build_good_frame(1'b1);
         end else if (r < 88) begin
            build_short_length();
         end else if (r < 96) begin
            build_short_control();
         end else begin
            build_noise();
         end
         send_frame();
         if (frame_idx % 25 == 24) begin
            wait_idle();
         end
         frame_idx++;
      end

      wait_idle();
      repeat (20) @(posedge clock);
      $display("Sent %0d requests in %0d frames, %0d of them parsed.", requests_sent,
               frame_idx, parsed_count);
      $display("Checked %0d headers, %0d payload bytes and %0d length errors.",
               headers_seen, payload_seen, errors_seen);
      if (fail_count == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule
